FILE: sv/hbkd_pkg.sv
// Shared types, constants and the scan-code translation table of the boot
// keyboard report decoder. No dependencies.
`default_nettype none

package hbkd_pkg;

	// Number of key slots carried by one boot-protocol report.
	localparam int SLOT_COUNT = 6;

	typedef logic [7:0] key_code_t;
	typedef logic [6:0] ascii_t;
	typedef logic [SLOT_COUNT-1:0] slot_mask_t;
	typedef key_code_t [SLOT_COUNT-1:0] key_row_t;
	typedef ascii_t [SLOT_COUNT-1:0] ascii_row_t;

	// What one lane reports about its slot.
	typedef struct packed {
		logic   emit;
		ascii_t char_code;
	} lane_result_t;

	// Characters produced by the table.
	localparam ascii_t CH_BANG      = 7'h21;
	localparam ascii_t CH_LOWER_A   = 7'h61;
	localparam ascii_t CH_DIGIT_1   = 7'h31;
	localparam ascii_t CH_DIGIT_0   = 7'h30;
	localparam ascii_t CH_NEWLINE   = 7'h0a;
	localparam ascii_t CH_BACKSPACE = 7'h08;
	localparam ascii_t CH_TAB       = 7'h09;
	localparam ascii_t CH_SPACE     = 7'h20;
	localparam ascii_t CH_MINUS     = 7'h2d;
	localparam ascii_t CH_EQUALS    = 7'h3d;
	localparam ascii_t CH_LBRACKET  = 7'h5b;
	localparam ascii_t CH_RBRACKET  = 7'h5d;
	localparam ascii_t CH_BACKSLASH = 7'h5c;
	localparam ascii_t CH_SEMICOLON = 7'h3b;
	localparam ascii_t CH_QUOTE     = 7'h27;
	localparam ascii_t CH_COMMA     = 7'h2c;
	localparam ascii_t CH_PERIOD    = 7'h2e;
	localparam ascii_t CH_SLASH     = 7'h2f;
	localparam ascii_t CH_NUL       = 7'h00;

	// Usage codes that bound the letter and digit runs.
	localparam key_code_t CODE_A      = 8'd4;
	localparam key_code_t CODE_Z      = 8'd29;
	localparam key_code_t CODE_1      = 8'd30;
	localparam key_code_t CODE_9      = 8'd38;
	localparam key_code_t CODE_0      = 8'd39;
	localparam key_code_t CODE_ENTER  = 8'd40;
	localparam key_code_t CODE_BKSP   = 8'd42;
	localparam key_code_t CODE_TAB    = 8'd43;
	localparam key_code_t CODE_SPACE  = 8'd44;
	localparam key_code_t CODE_MINUS  = 8'd45;
	localparam key_code_t CODE_EQUAL  = 8'd46;
	localparam key_code_t CODE_LBRACK = 8'd47;
	localparam key_code_t CODE_RBRACK = 8'd48;
	localparam key_code_t CODE_BSLASH = 8'd49;
	localparam key_code_t CODE_SEMI   = 8'd51;
	localparam key_code_t CODE_QUOTE  = 8'd52;
	localparam key_code_t CODE_COMMA  = 8'd54;
	localparam key_code_t CODE_PERIOD = 8'd55;
	localparam key_code_t CODE_SLASH  = 8'd56;

	// Scan-code to character table. Codes with the top bit set give NUL;
	// anything without its own character gives an exclamation mark.
	function automatic ascii_t translate_code(input key_code_t code);
		key_code_t offset;
		ascii_t    result;
		offset = 8'd0;
		result = CH_BANG;
		if (code[7]) begin
			result = CH_NUL;
		end else if (code >= CODE_A && code <= CODE_Z) begin
			offset = code - CODE_A;
			result = CH_LOWER_A + offset[6:0];
		end else if (code >= CODE_1 && code <= CODE_9) begin
			offset = code - CODE_1;
			result = CH_DIGIT_1 + offset[6:0];
		end else begin
			case (code)
				CODE_0:      result = CH_DIGIT_0;
				CODE_ENTER:  result = CH_NEWLINE;
				CODE_BKSP:   result = CH_BACKSPACE;
				CODE_TAB:    result = CH_TAB;
				CODE_SPACE:  result = CH_SPACE;
				CODE_MINUS:  result = CH_MINUS;
				CODE_EQUAL:  result = CH_EQUALS;
				CODE_LBRACK: result = CH_LBRACKET;
				CODE_RBRACK: result = CH_RBRACKET;
				CODE_BSLASH: result = CH_BACKSLASH;
				CODE_SEMI:   result = CH_SEMICOLON;
				CODE_QUOTE:  result = CH_QUOTE;
				CODE_COMMA:  result = CH_COMMA;
				CODE_PERIOD: result = CH_PERIOD;
				CODE_SLASH:  result = CH_SLASH;
				default:     result = CH_BANG;
			endcase
		end
		return result;
	endfunction

endpackage

`default_nettype wire

FILE: sv/hbkd_lane.sv
// One slot lane: decides whether its key is reported and translates it.
// Depends on hbkd_pkg.
`default_nettype none

module hbkd_lane
	import hbkd_pkg::*;
(
	input  key_code_t    code,
	input  key_row_t     prev_keys,
	input  logic         same_report,
	output lane_result_t result
);

	logic [SLOT_COUNT-1:0] hit;
	logic                  seen;

	// Look for this code anywhere in the previous report.
	always_comb begin
		for (int j = 0; j < SLOT_COUNT; j++) begin
			hit[j] = (code == prev_keys[j]);
		end
	end
	assign seen = |hit;

	// Empty slots never report; a repeated report reports every key.
	assign result.emit      = (code != 8'd0) && (same_report || !seen);
	assign result.char_code = translate_code(code);

endmodule

`default_nettype wire

FILE: sv/hbkd_serializer.sv
// Merging stage: holds the lane results of one report and hands the
// characters out one per item in slot order. Depends on hbkd_pkg.
`default_nettype none

module hbkd_serializer
	import hbkd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  slot_mask_t load_mask,
	input  ascii_row_t load_chars,
	output logic       busy,
	output logic       final_pending,
	output ascii_t     char_code,
	output logic       last,
	input  logic       take
);

	slot_mask_t mask_q;
	ascii_row_t chars_q;
	slot_mask_t pick;
	slot_mask_t remaining;

	// Lowest pending slot goes first.
	assign pick      = mask_q & (~mask_q + 1'b1);
	assign remaining = mask_q & ~pick;
	assign busy      = |mask_q;
	assign last      = (remaining == '0);
	assign final_pending = busy && last;

	always_comb begin
		char_code = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (pick[i]) begin
				char_code = char_code | chars_q[i];
			end
		end
	end

	// Pending slots: reload on a new report, otherwise retire the one taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= load_mask;
		end else if (take && busy) begin
			mask_q <= remaining;
		end
	end

	// Character payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= load_chars;
		end
	end

endmodule

`default_nettype wire

FILE: sv/hid_boot_keyboard_report_decoder.sv
// Top level of the boot keyboard report decoder. Depends on hbkd_pkg,
// hbkd_lane and hbkd_serializer.
`default_nettype none

// Each input item is the six key slots of one boot-protocol keyboard report.
// Six lanes compare their slot against the previous report in the cycle the
// item is accepted; the merging stage then puts out one character per cycle
// while out_ready is high, in slot order, with last_of_report on the final
// one. A report has 0 to 6 characters to emit, and the next report is
// accepted in the same cycle as the final character leaves, so a new report
// is not taken while the merging stage still holds characters of the last.
// A report with nothing to emit gives no output item and still becomes the
// previous report.
module hid_boot_keyboard_report_decoder
	import hbkd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] key_slot_0,
	input  logic [7:0] key_slot_1,
	input  logic [7:0] key_slot_2,
	input  logic [7:0] key_slot_3,
	input  logic [7:0] key_slot_4,
	input  logic [7:0] key_slot_5,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] ascii_char,
	output logic       last_of_report
);

	key_row_t     cur_keys;
	key_row_t     prev_keys_q;
	logic         same_report;
	lane_result_t lane_res [SLOT_COUNT];
	slot_mask_t   emit_mask;
	ascii_row_t   lane_chars;
	logic         accept;
	logic         busy;
	logic         final_pending;

	assign cur_keys = {key_slot_5, key_slot_4, key_slot_3,
		key_slot_2, key_slot_1, key_slot_0};

	// A report identical to the previous one is a key repeat.
	assign same_report = (cur_keys == prev_keys_q);

	// Lanes, one per slot.
	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_lane
		hbkd_lane u_lane (
			.code        (cur_keys[i]),
			.prev_keys   (prev_keys_q),
			.same_report (same_report),
			.result      (lane_res[i])
		);
		assign emit_mask[i]  = lane_res[i].emit;
		assign lane_chars[i] = lane_res[i].char_code;
	end

	// Take a new report when idle or as the last character leaves.
	assign in_ready = !busy || (final_pending && out_ready);
	assign accept   = in_valid && in_ready;

	// The accepted report becomes the reference for the next one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_keys_q <= '0;
		end else if (accept) begin
			prev_keys_q <= cur_keys;
		end
	end

	hbkd_serializer u_serializer (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (accept),
		.load_mask     (emit_mask),
		.load_chars    (lane_chars),
		.busy          (busy),
		.final_pending (final_pending),
		.char_code     (ascii_char),
		.last          (last_of_report),
		.take          (out_ready)
	);

	assign out_valid = busy;

endmodule

`default_nettype wire

FILE: sv/hbkd_checker.sv
// Port-level checks for the boot keyboard report decoder, bound to the top
// level. No package dependency.
`default_nettype none

module hbkd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] ascii_char,
	input logic       last_of_report
);

	// A stalled character holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ascii_char)
			&& $stable(last_of_report))
		else $error("output item changed while stalled");

	// A report that is not finished keeps producing characters.
	a_report_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_report |=> out_valid)
		else $error("report ended without last_of_report");

	// No new report enters while the current one has characters to go.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_report |-> !in_ready)
		else $error("input accepted in the middle of a report");

	// With nothing to deliver the block is always ready.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("idle block not ready for input");

endmodule

bind hid_boot_keyboard_report_decoder hbkd_checker u_hbkd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.ascii_char     (ascii_char),
	.last_of_report (last_of_report)
);

`default_nettype wire

FILE: tb/sv/tb_hid_boot_keyboard_report_decoder.sv
// Self-checking testbench for the boot keyboard report decoder: a queue-fed driver,
// a checking monitor and an independent predictor of the emitted characters.
// Depends on hbkd_pkg and hid_boot_keyboard_report_decoder.
`default_nettype none

module tb_hid_boot_keyboard_report_decoder
	import hbkd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REPORTS = 350;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 16;

	// Characters for the punctuation run, usage codes 40 to 56 in order.
	localparam ascii_t PUNCT_CHARS [0:16] = '{
		7'h0a, 7'h21, 7'h08, 7'h09, 7'h20, 7'h2d, 7'h3d, 7'h5b, 7'h5d,
		7'h5c, 7'h21, 7'h3b, 7'h27, 7'h21, 7'h2c, 7'h2e, 7'h2f
	};

	// One report waiting to be offered, with the idle time that follows it.
	typedef struct {
		key_row_t    keys;
		int unsigned gap_after;
		bit          wait_drain;
	} report_item_t;

	// One character that the decoder should put out.
	typedef struct packed {
		ascii_t ch;
		logic   last;
	} key_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] ascii_char;
	logic       last_of_report;
	key_row_t   drive_keys = '0;

	report_item_t pending_reports[$];
	key_char_t    expected_chars[$];
	key_row_t     held_keys = '0;
	int unsigned  idle_left = 0;
	int unsigned  hold_left = 0;
	int unsigned  rx_cycles = 0;
	int unsigned  chars_seen = 0;
	bit           long_hold_done = 1'b0;
	int unsigned  queued_count = 0;
	int           errors = 0;

	hid_boot_keyboard_report_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.key_slot_0     (drive_keys[0]),
		.key_slot_1     (drive_keys[1]),
		.key_slot_2     (drive_keys[2]),
		.key_slot_3     (drive_keys[3]),
		.key_slot_4     (drive_keys[4]),
		.key_slot_5     (drive_keys[5]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ascii_char     (ascii_char),
		.last_of_report (last_of_report)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Scan-code translation, written out independently of the design.
	function automatic ascii_t char_of_code(input key_code_t code);
		ascii_t ch;
		if (code >= 8'd128) begin
			ch = CH_NUL;
		end else if (code >= CODE_A && code <= CODE_Z) begin
			ch = ascii_t'(8'd97 + code - CODE_A);
		end else if (code >= CODE_1 && code <= CODE_9) begin
			ch = ascii_t'(8'd49 + code - CODE_1);
		end else if (code == CODE_0) begin
			ch = CH_DIGIT_0;
		end else if (code >= CODE_ENTER && code <= CODE_SLASH) begin
			ch = PUNCT_CHARS[code - CODE_ENTER];
		end else begin
			ch = CH_BANG;
		end
		return ch;
	endfunction

	// Works out the characters one accepted report produces and moves the
	// report into the held state.
	function automatic void decode_report(input key_row_t keys);
		key_char_t found[$];
		key_char_t c;
		bit        repeat_all;
		bit        seen;
		repeat_all = (keys == held_keys);
		for (int s = 0; s < SLOT_COUNT; s++) begin
			seen = 1'b0;
			for (int p = 0; p < SLOT_COUNT; p++) begin
				if (keys[s] == held_keys[p]) begin
					seen = 1'b1;
				end
			end
			if (keys[s] != 8'd0 && (repeat_all || !seen)) begin
				c.ch = char_of_code(keys[s]);
				c.last = 1'b0;
				found.push_back(c);
			end
		end
		if (found.size() > 0) begin
			found[found.size() - 1].last = 1'b1;
		end
		foreach (found[i]) begin
			expected_chars.push_back(found[i]);
		end
		held_keys = keys;
	endfunction

	// Idle time after an item: bursts with none, otherwise mostly short.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if ((queued_count / 24) % 3 == 1) begin
			return 0;
		end else if (roll < 65) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void add_report(input key_row_t keys, input bit wait_drain);
		report_item_t item;
		item.keys = keys;
		item.gap_after = pick_gap();
		item.wait_drain = wait_drain;
		pending_reports.push_back(item);
		queued_count++;
	endfunction

	function automatic key_row_t make_row(input int s0, input int s1, input int s2,
		input int s3, input int s4, input int s5);
		key_row_t r;
		r[0] = key_code_t'(s0);
		r[1] = key_code_t'(s1);
		r[2] = key_code_t'(s2);
		r[3] = key_code_t'(s3);
		r[4] = key_code_t'(s4);
		r[5] = key_code_t'(s5);
		return r;
	endfunction

	// Mostly codes with a defined character, now and then anything at all.
	function automatic key_code_t typical_code();
		if ($urandom_range(0, 9) == 0) begin
			return key_code_t'($urandom_range(0, 255));
		end
		return key_code_t'($urandom_range(1, 60));
	endfunction

	// Next report of a typing session: held keys, presses and releases,
	// reordered slots, empty reports, and some pure noise.
	function automatic key_row_t next_row(input key_row_t prev);
		key_row_t    r;
		int unsigned roll;
		int unsigned sh;
		roll = $urandom_range(0, 99);
		r = prev;
		if (roll < 20) begin
			r = prev;
		end else if (roll < 50) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				if ($urandom_range(0, 3) == 0) begin
					r[s] = ($urandom_range(0, 2) == 0) ? 8'd0 : typical_code();
				end
			end
		end else if (roll < 62) begin
			sh = $urandom_range(1, SLOT_COUNT - 1);
			for (int s = 0; s < SLOT_COUNT; s++) begin
				r[s] = prev[(s + sh) % SLOT_COUNT];
			end
		end else if (roll < 70) begin
			r = '0;
		end else if (roll < 88) begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				r[s] = ($urandom_range(0, 2) == 0) ? 8'd0 : typical_code();
			end
		end else begin
			for (int s = 0; s < SLOT_COUNT; s++) begin
				r[s] = key_code_t'($urandom_range(0, 255));
			end
		end
		return r;
	endfunction

	// Driver: predicts each accepted item and offers the next one from the queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drive_keys <= '0;
			idle_left <= 0;
			held_keys = '0;
		end else begin
			if (in_valid && in_ready) begin
				decode_report(drive_keys);
			end
			if (!in_valid || in_ready) begin
				if (idle_left > 0) begin
					idle_left <= idle_left - 1;
					in_valid <= 1'b0;
				end else if (pending_reports.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_reports[0].wait_drain && expected_chars.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					drive_keys <= pending_reports[0].keys;
					idle_left <= pending_reports[0].gap_after;
					in_valid <= 1'b1;
					void'(pending_reports.pop_front());
				end
			end
		end
	end

	// Monitor: checks every accepted character and paces the output side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			rx_cycles <= 0;
			chars_seen <= 0;
			long_hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				chars_seen <= chars_seen + 1;
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected item, got char %h last %b",
						$time, ascii_char, last_of_report);
					errors++;
				end else begin
					if (ascii_char !== expected_chars[0].ch ||
						last_of_report !== expected_chars[0].last) begin
						$display("%0t: mismatch, expected char %h last %b, got char %h last %b",
							$time, expected_chars[0].ch, expected_chars[0].last,
							ascii_char, last_of_report);
						errors++;
					end
					void'(expected_chars.pop_front());
				end
			end
			rx_cycles <= rx_cycles + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (!long_hold_done && chars_seen >= 60) begin
				// One long hold-off so that the decoder backs up into its input.
				long_hold_done <= 1'b1;
				hold_left <= LONG_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (rx_cycles[8:7] == 2'd0) begin
				out_ready <= 1'b1;
			end else if ($urandom_range(0, 99) < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				hold_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		key_row_t last_row;
		// Empty after empty, then fresh keys and a full repeat.
		add_report(make_row(0, 0, 0, 0, 0, 0), 1'b0);
		add_report(make_row(4, 5, 6, 7, 8, 9), 1'b0);
		add_report(make_row(4, 5, 6, 7, 8, 9), 1'b0);
		// Every edge of the translation table.
		add_report(make_row(29, 30, 38, 39, 40, 41), 1'b0);
		add_report(make_row(42, 43, 44, 45, 46, 47), 1'b0);
		add_report(make_row(48, 49, 50, 51, 52, 53), 1'b0);
		add_report(make_row(54, 55, 56, 57, 127, 1), 1'b0);
		add_report(make_row(128, 255, 2, 3, 200, 0), 1'b0);
		add_report(make_row(128, 255, 2, 3, 200, 0), 1'b0);
		// Same keys in other slots: all seen before, nothing to emit.
		add_report(make_row(0, 128, 255, 2, 3, 200), 1'b0);
		// Duplicate codes, then a partial overlap with the previous report.
		add_report(make_row(5, 5, 0, 5, 0, 5), 1'b0);
		add_report(make_row(5, 6, 0, 0, 0, 0), 1'b0);
		add_report(make_row(0, 0, 0, 0, 0, 0), 1'b0);
		add_report(make_row(0, 0, 0, 0, 0, 0), 1'b0);
		// Alternating bit patterns, the first offered only once the output has drained.
		add_report(make_row(8'h55, 8'hAA, 8'hFF, 8'h01, 8'h80, 8'h7F), 1'b1);
		add_report(make_row(8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h40, 8'h20), 1'b0);
		last_row = make_row(8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h40, 8'h20);
		for (int i = 0; i < RANDOM_REPORTS; i++) begin
			last_row = next_row(last_row);
			add_report(last_row, (i % 45) == 44);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (pending_reports.size() != 0 || in_valid || expected_chars.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && expected_chars.size() == 0) begin
			$display("tb_hid_boot_keyboard_report_decoder: clean");
		end else begin
			$display("tb_hid_boot_keyboard_report_decoder: errors");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin : watchdog
		#20_000_000;
		$display("tb_hid_boot_keyboard_report_decoder: errors");
		$finish;
	end

endmodule

`default_nettype wire
